>>> design/plcm_pkg.sv
// Package for the curve map unit: constants, breakpoint table, microcode and control types.
package plcm_pkg;

  // Curve geometry.
  localparam int POINTS_PER_CURVE = 8;
  localparam int CURVE_COUNT      = 4;
  localparam int CURVE_STRIDE     = 2 * POINTS_PER_CURVE;
  localparam int K_W              = (POINTS_PER_CURVE > 2) ? $clog2(POINTS_PER_CURVE) : 1;

  // Data widths.
  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 10;
  localparam int FRAME_W   = 11;
  localparam int DATA_W    = 15;
  localparam int SHIFT     = 5;
  localparam int NUM_W     = 2 * DATA_W;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int ROM_AW    = 6;
  localparam int ROM_DEPTH = 1 << ROM_AW;
  localparam int CUR_W     = 2;
  localparam int UPC_W     = 4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1023;
  localparam logic [FRAME_W-1:0] WRITE_CMD = 11'h400;

  // Breakpoint table: per curve, x breakpoints then y breakpoints.
  localparam logic [DATA_W-1:0] BP_ROM [ROM_DEPTH] = '{
    15'd0,     15'd5734,  15'd11693, 15'd16030, 15'd19274, 15'd21684, 15'd29121, 15'd32767,
    15'd0,     15'd1478,  15'd6579,  15'd13111, 15'd22962, 15'd26764, 15'd29850, 15'd32767,
    15'd0,     15'd3400,  15'd9726,  15'd16331, 15'd19395, 15'd22078, 15'd25416, 15'd32767,
    15'd1612,  15'd6132,  15'd22206, 15'd32767, 15'd13003, 15'd4342,  15'd807,   15'd0,
    15'd0,     15'd2219,  15'd7419,  15'd10704, 15'd16275, 15'd20965, 15'd24791, 15'd32767,
    15'd5264,  15'd10757, 15'd28662, 15'd32767, 15'd29869, 15'd8733,  15'd1838,  15'd0,
    15'd0,     15'd3468,  15'd9517,  15'd11880, 15'd15385, 15'd25149, 15'd28630, 15'd32767,
    15'd32767, 15'd32249, 15'd10444, 15'd5091,  15'd1519,  15'd363,   15'd180,   15'd80
  };

  // Table address of breakpoint idx of a curve, x half or y half.
  function automatic logic [ROM_AW-1:0] rom_addr(input logic [CUR_W-1:0] cur,
                                                 input logic is_y,
                                                 input logic [K_W-1:0] idx);
    int a;
    a = int'(cur) * CURVE_STRIDE + (is_y ? POINTS_PER_CURVE : 0) + int'(idx);
    return a[ROM_AW-1:0];
  endfunction

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_INIT,
    OP_SINIT,
    OP_SRCH,
    OP_LDXS,
    OP_LDDX,
    OP_LDYS,
    OP_LDDY,
    OP_MUL,
    OP_DSET,
    OP_DIV,
    OP_FIN,
    OP_DONE
  } uop_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_IDLE,
    JC_SRCH,
    JC_DIV,
    JC_CURVE
  } jcond_t;

  typedef struct packed {
    uop_t             op;
    jcond_t           cond;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // Control from sequencer to datapath.
  typedef struct packed {
    uop_t op;
    logic load;
  } ctl_t;

  // Loop status from datapath to sequencer.
  typedef struct packed {
    logic srch_more;
    logic div_more;
    logic curve_more;
  } stat_t;

  // Step addresses.
  localparam logic [UPC_W-1:0] S_WAIT  = 4'd0;
  localparam logic [UPC_W-1:0] S_SINIT = 4'd1;
  localparam logic [UPC_W-1:0] S_SRCH  = 4'd2;
  localparam logic [UPC_W-1:0] S_LDXS  = 4'd3;
  localparam logic [UPC_W-1:0] S_LDDX  = 4'd4;
  localparam logic [UPC_W-1:0] S_LDYS  = 4'd5;
  localparam logic [UPC_W-1:0] S_LDDY  = 4'd6;
  localparam logic [UPC_W-1:0] S_MUL   = 4'd7;
  localparam logic [UPC_W-1:0] S_DSET  = 4'd8;
  localparam logic [UPC_W-1:0] S_DIV   = 4'd9;
  localparam logic [UPC_W-1:0] S_FIN   = 4'd10;
  localparam logic [UPC_W-1:0] S_DONE  = 4'd11;

  // Microprogram.
  function automatic ucw_t ucode_rd(input logic [UPC_W-1:0] upc);
    ucw_t w;
    case (upc)
      S_WAIT:  w = '{op: OP_INIT,  cond: JC_IDLE,   target: S_WAIT};
      S_SINIT: w = '{op: OP_SINIT, cond: JC_NEXT,   target: S_WAIT};
      S_SRCH:  w = '{op: OP_SRCH,  cond: JC_SRCH,   target: S_SRCH};
      S_LDXS:  w = '{op: OP_LDXS,  cond: JC_NEXT,   target: S_WAIT};
      S_LDDX:  w = '{op: OP_LDDX,  cond: JC_NEXT,   target: S_WAIT};
      S_LDYS:  w = '{op: OP_LDYS,  cond: JC_NEXT,   target: S_WAIT};
      S_LDDY:  w = '{op: OP_LDDY,  cond: JC_NEXT,   target: S_WAIT};
      S_MUL:   w = '{op: OP_MUL,   cond: JC_NEXT,   target: S_WAIT};
      S_DSET:  w = '{op: OP_DSET,  cond: JC_NEXT,   target: S_WAIT};
      S_DIV:   w = '{op: OP_DIV,   cond: JC_DIV,    target: S_DIV};
      S_FIN:   w = '{op: OP_FIN,   cond: JC_CURVE,  target: S_SINIT};
      S_DONE:  w = '{op: OP_DONE,  cond: JC_ALWAYS, target: S_WAIT};
      default: w = '{op: OP_DONE,  cond: JC_ALWAYS, target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> design/piecewise_linear_curve_map_unit.sv
// Top level of the piecewise linear curve map unit.
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+------------------------------
//  input    | in_control_sample                       | accepted when start && !busy
//  result   | out_curve_*_value, out_pot_frame_*      | out_valid, one cycle, no stall
//
// The time from acceptance to the result strobe is set by the shared one-bit-per-cycle
// divider run once per curve, together with the serial breakpoint search through the
// single table read port; the next item is taken in the strobe cycle.
// Reset clears the step counter and the strobe; results cannot be stalled and
// stay on the ports until the next item's evaluation overwrites them.
module piecewise_linear_curve_map_unit import plcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] in_control_sample,
  output logic                out_valid,
  output logic [VALUE_W-1:0]  out_curve_a_value,
  output logic [VALUE_W-1:0]  out_curve_b_value,
  output logic [VALUE_W-1:0]  out_curve_c_value,
  output logic [VALUE_W-1:0]  out_curve_d_value,
  output logic [FRAME_W-1:0]  out_pot_frame_a,
  output logic [FRAME_W-1:0]  out_pot_frame_b,
  output logic [FRAME_W-1:0]  out_pot_frame_c,
  output logic [FRAME_W-1:0]  out_pot_frame_d
);

  ctl_t               ctl;
  stat_t              stat;
  logic [VALUE_W-1:0] value [4];
  logic [FRAME_W-1:0] frame [4];

  // Sequencer.
  plcm_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Datapath.
  plcm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (in_control_sample),
    .stat      (stat),
    .out_valid (out_valid),
    .value     (value)
  );

  // Write frames carry the command bit over the inverted wiper code.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      frame[c] = (c < CURVE_COUNT) ? (WRITE_CMD | {1'b0, ~value[c]}) : WRITE_CMD;
    end
  end

  assign out_curve_a_value = value[0];
  assign out_curve_b_value = value[1];
  assign out_curve_c_value = value[2];
  assign out_curve_d_value = value[3];
  assign out_pot_frame_a   = frame[0];
  assign out_pot_frame_b   = frame[1];
  assign out_pot_frame_c   = frame[2];
  assign out_pot_frame_d   = frame[3];

`ifndef SYNTHESIS
  // An accepted item keeps the unit busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting an item");

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // A result is only shown once the sequence has returned to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // The unit leaves idle only by accepting an item.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("unit became busy without an item");
`endif

endmodule

>>> design/plcm_useq.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
module plcm_useq import plcm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  ucw_t             cw;
  logic             taken;

  // Fetch the control word of the current step.
  assign cw   = ucode_rd(upc_r);
  assign busy = (upc_r != S_WAIT);

  // Evaluate the jump condition and pick the next step.
  always_comb begin
    case (cw.cond)
      JC_NEXT:   taken = 1'b0;
      JC_ALWAYS: taken = 1'b1;
      JC_IDLE:   taken = !start;
      JC_SRCH:   taken = stat.srch_more;
      JC_DIV:    taken = stat.div_more;
      JC_CURVE:  taken = stat.curve_more;
      default:   taken = 1'b0;
    endcase
    upc_nxt = taken ? cw.target : upc_r + UPC_W'(1);
    ctl.op   = cw.op;
    ctl.load = start && !busy;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> design/plcm_dpath.sv
// Datapath: segment search, difference registers, multiplier, serial divider and result store.
module plcm_dpath import plcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_t                ctl,
  input  logic [SAMPLE_W-1:0] sample,
  output stat_t               stat,
  output logic                out_valid,
  output logic [VALUE_W-1:0]  value [4]
);

  logic [DATA_W-1:0]         x_r;
  logic [CUR_W-1:0]          cur_r;
  logic [K_W-1:0]            k_r, seg_r;
  logic [DATA_W-1:0]         xs_r, ys_r, t_r;
  logic signed [DATA_W:0]    dx_r, dy_r;
  logic signed [31:0]        prod_r;
  logic [NUM_W-1:0]          num_r;
  logic [DATA_W-1:0]         rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      neg_r;
  logic                      valid_r;
  logic [VALUE_W-1:0]        val_r [4];

  logic [ROM_AW-1:0]         addr;
  logic [DATA_W-1:0]         rd;
  logic [VALUE_W-1:0]        sat;
  logic [DATA_W:0]           tdiff;
  logic [DATA_W+1:0]         trial;
  logic [31:0]               prod_abs;
  logic signed [31:0]        delta, sum;
  logic [26:0]               sum_sh;
  logic [VALUE_W-1:0]        fin_val;
  logic [K_W-1:0]            seg_inc;

  assign seg_inc = seg_r + K_W'(1);

  // Loop status for the sequencer.
  assign stat.srch_more  = ({1'b0, k_r} + (K_W+1)'(1)) < (K_W+1)'(POINTS_PER_CURVE - 1);
  assign stat.div_more   = (cnt_r != CNT_W'(1));
  assign stat.curve_more = (int'(cur_r) < CURVE_COUNT - 1);

  // Breakpoint table address depends on the current operation.
  always_comb begin
    case (ctl.op)
      OP_SRCH: addr = rom_addr(cur_r, 1'b0, k_r);
      OP_LDXS: addr = rom_addr(cur_r, 1'b0, seg_r);
      OP_LDDX: addr = rom_addr(cur_r, 1'b0, seg_inc);
      OP_LDYS: addr = rom_addr(cur_r, 1'b1, seg_r);
      OP_LDDY: addr = rom_addr(cur_r, 1'b1, seg_inc);
      default: addr = rom_addr(cur_r, 1'b0, seg_r);
    endcase
  end
  assign rd = BP_ROM[addr];

  // Arithmetic of the individual steps.
  always_comb begin
    sat      = (sample > SAMPLE_W'(VALUE_MAX)) ? VALUE_MAX : sample[VALUE_W-1:0];
    tdiff    = {1'b0, x_r} - {1'b0, rd};
    trial    = {1'b0, rem_r, num_r[NUM_W-1]} - {2'b00, dx_r[DATA_W-1:0]};
    prod_abs = prod_r[31] ? 32'(-prod_r) : 32'(prod_r);
    if (dx_r > 0) begin
      delta = neg_r ? -$signed(32'(num_r)) : $signed(32'(num_r));
    end else begin
      delta = '0;
    end
    sum    = $signed({17'b0, ys_r}) + delta;
    sum_sh = sum[31:SHIFT];
    if (sum[31]) begin
      fin_val = '0;
    end else if (sum_sh > 27'(VALUE_MAX)) begin
      fin_val = VALUE_MAX;
    end else begin
      fin_val = sum_sh[VALUE_W-1:0];
    end
  end

  // Working registers, updated by the operation of each step.
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INIT: begin
        if (ctl.load) begin
          x_r   <= {sat, {SHIFT{1'b0}}};
          cur_r <= '0;
        end
      end
      OP_SINIT: begin
        k_r   <= K_W'(1);
        seg_r <= '0;
      end
      OP_SRCH: begin
        if (int'(k_r) < POINTS_PER_CURVE - 1) begin
          if (rd <= x_r) begin
            seg_r <= k_r;
          end
          k_r <= k_r + K_W'(1);
        end
      end
      OP_LDXS: begin
        xs_r <= rd;
        t_r  <= tdiff[DATA_W] ? '0 : tdiff[DATA_W-1:0];
      end
      OP_LDDX: dx_r <= $signed({1'b0, rd}) - $signed({1'b0, xs_r});
      OP_LDYS: ys_r <= rd;
      OP_LDDY: dy_r <= $signed({1'b0, rd}) - $signed({1'b0, ys_r});
      OP_MUL:  prod_r <= 32'(dy_r) * 32'($signed({1'b0, t_r}));
      OP_DSET: begin
        num_r <= prod_abs[NUM_W-1:0];
        neg_r <= prod_r[31];
        rem_r <= '0;
        cnt_r <= CNT_W'(NUM_W);
      end
      OP_DIV: begin
        // One restoring division step: quotient bits shift in from the right.
        if (!trial[DATA_W+1]) begin
          rem_r <= trial[DATA_W-1:0];
          num_r <= {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DATA_W-2:0], num_r[NUM_W-1]};
          num_r <= {num_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_FIN: begin
        val_r[cur_r] <= fin_val;
        if (stat.curve_more) begin
          cur_r <= cur_r + CUR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result strobe for one cycle after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctl.op == OP_DONE);
    end
  end

  assign out_valid = valid_r;

  // Curves beyond the configured count read as zero.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      value[c] = (c < CURVE_COUNT) ? val_r[c] : '0;
    end
  end

endmodule
